### rtl/gf2au_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the GF(2^n) arithmetic unit.
// No dependencies; imported by gf2n_arithmetic_unit_core.
package gf2au_pkg;

    localparam int GF_MAX_DEGREE    = 32;
    localparam int DATA_WIDTH       = 32;
    localparam int DEG_WIDTH        = 6;
    localparam int CFG_DATA_WIDTH   = 33;
    localparam int CFG_INDEX_WIDTH  = 1;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FIELD_DEGREE     = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FIELD_POLYNOMIAL = 1'b1;

    // Values after reset: x^8 + x^4 + x^3 + x + 1.
    localparam int                        DEG_RESET  = 8;
    localparam logic [CFG_DATA_WIDTH-1:0] POLY_RESET = 33'h11B;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_INV = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [DATA_WIDTH-1:0] operand_a;
        logic [DATA_WIDTH-1:0] operand_b;
    } t_request;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] result;
        logic                  zero_inverse;
    } t_response;

endpackage

### rtl/gf2n_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// Top level of the GF(2^n) arithmetic unit: add, multiply, inverse and divide.
// Depends on gf2au_pkg for the request and response types and the register codes.
//
// Usage
// -----
// A request (op, operand_a, operand_b) is taken at a rising edge where start is
// high and busy is low. Exactly one response follows, shown on o_response for a
// single cycle while o_done is high. The receiver cannot hold a response off, so
// it must capture it in that cycle. The next request may be presented during the
// cycle in which the previous response is shown.
// How each operation proceeds after the accepting edge:
//   add        the sum of the operands is registered directly
//   multiply   one multiplier bit per cycle, most significant first
//   inverse    a zero result for a zero operand, otherwise extended Euclid steps
//              on P and the operand. Each cycle clears one remainder bit or aligns
//              the divisor by one place.
//   divide     a zero result for a zero divisor, otherwise the inverse of operand_b
//              followed by a multiply.
// The field register pair (degree and polynomial) is written through the plain
// write port. Only write it while the unit is idle; the block does not enforce it.
// Synchronous reset returns the unit to idle with degree 8 and polynomial 0x11B.
module gf2n_arithmetic_unit_core
    import gf2au_pkg::*;
#(
    parameter int MAX_DEGREE = GF_MAX_DEGREE
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  t_request                   i_request,
    output logic                       o_done,
    output t_response                  o_response,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    // W holds a polynomial of full degree; CW counts degrees 0..MAX_DEGREE.
    localparam int W  = MAX_DEGREE + 1;
    localparam int CW = $clog2(MAX_DEGREE + 1);
    localparam int IW = $clog2(MAX_DEGREE);
    localparam int DEG_RESET_EFF = (DEG_RESET > MAX_DEGREE) ? MAX_DEGREE : DEG_RESET;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_DIVI,
        ST_MUL
    } t_state;

    // Field configuration. The degree is stored already clamped to 1..MAX_DEGREE.
    logic [CW-1:0]           r_n;
    logic [W-1:0]            r_poly_raw;

    // Control.
    t_state                  r_state;
    t_op                     r_op;
    logic                    r_done;
    t_response               r_resp;

    // Euclid datapath: remainder pair (r, v) and coefficient pair (s, w).
    // v and w hold the divisor and its coefficient shifted up by r_dr - r_dn.
    logic [W-1:0]            r_r;
    logic [W-1:0]            r_s;
    logic [W-1:0]            r_v;
    logic [W-1:0]            r_w;
    logic [CW-1:0]           r_dr;
    logic [CW-1:0]           r_dn;

    // Serial multiplier: accumulator, multiplier shift register, multiplicand.
    logic [MAX_DEGREE-1:0]   r_acc;
    logic [MAX_DEGREE-1:0]   r_mb;
    logic [MAX_DEGREE-1:0]   r_a;
    logic [CW-1:0]           r_cnt;

    logic [MAX_DEGREE-1:0]   mask;
    logic [W-1:0]            poly_eff;
    logic [MAX_DEGREE-1:0]   op_a;
    logic [MAX_DEGREE-1:0]   op_b;
    logic [MAX_DEGREE-1:0]   inv_src;
    logic [DEG_WIDTH-1:0]    cfg_deg;
    logic [CW-1:0]           cfg_n;
    logic                    div_bit;
    logic [W-1:0]            div_r;
    logic [W-1:0]            div_s;
    logic                    div_zero;
    logic [MAX_DEGREE-1:0]   inv_res;
    logic [W-1:0]            mul_t;
    logic [IW-1:0]           mul_top;
    logic [MAX_DEGREE-1:0]   mul_acc;

    // The field mask and the effective polynomial: bits below n come from the
    // register, bit n is forced to one and everything above it is cleared.
    always_comb begin
        for (int i = 0; i < MAX_DEGREE; i++) begin
            mask[i] = (CW'(i) < r_n);
        end
        for (int i = 0; i < W; i++) begin
            poly_eff[i] = (CW'(i) < r_n) ? r_poly_raw[i] : (CW'(i) == r_n);
        end
    end

    assign op_a    = i_request.operand_a[MAX_DEGREE-1:0] & mask;
    assign op_b    = i_request.operand_b[MAX_DEGREE-1:0] & mask;
    assign inv_src = (i_request.op == OP_INV) ? op_a : op_b;

    // A degree of zero behaves as one, and one beyond the maximum as the maximum.
    assign cfg_deg = i_cfg_data[DEG_WIDTH-1:0];
    always_comb begin
        if (cfg_deg == '0) begin
            cfg_n = CW'(1);
        end else if (cfg_deg > DEG_WIDTH'(MAX_DEGREE)) begin
            cfg_n = CW'(MAX_DEGREE);
        end else begin
            cfg_n = CW'(cfg_deg);
        end
    end

    // One step of polynomial long division: if the remainder has its bit at the
    // current position set, subtract the aligned divisor and its coefficient.
    assign div_bit  = r_r[r_dr];
    assign div_r    = div_bit ? (r_r ^ r_v) : r_r;
    assign div_s    = div_bit ? (r_s ^ r_w) : r_s;
    assign div_zero = (div_r == '0);
    assign inv_res  = r_w[MAX_DEGREE-1:0] & mask;

    // One step of the most-significant-bit-first multiplier: double the
    // accumulator modulo the field polynomial, then add the multiplicand if the
    // current multiplier bit is set.
    assign mul_top = IW'(r_n - CW'(1));
    always_comb begin
        mul_t = {r_acc, 1'b0};
        if (mul_t[r_n]) begin
            mul_t = mul_t ^ poly_eff;
        end
        mul_acc = mul_t[MAX_DEGREE-1:0] ^ (r_mb[mul_top] ? r_a : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_done     <= 1'b0;
            r_n        <= CW'(DEG_RESET_EFF);
            r_poly_raw <= POLY_RESET[W-1:0];
        end else begin
            r_done <= 1'b0;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FIELD_DEGREE:     r_n        <= cfg_n;
                    CFG_FIELD_POLYNOMIAL: r_poly_raw <= i_cfg_data[W-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_op <= i_request.op;
                        r_a  <= op_a;
                        unique case (i_request.op)
                            OP_ADD: begin
                                r_done                  <= 1'b1;
                                r_resp.result           <= DATA_WIDTH'(op_a ^ op_b);
                                r_resp.zero_inverse     <= 1'b0;
                            end
                            OP_MUL: begin
                                r_acc   <= '0;
                                r_mb    <= op_b;
                                r_cnt   <= r_n - CW'(1);
                                r_state <= ST_MUL;
                            end
                            OP_INV, OP_DIV: begin
                                if (inv_src == '0) begin
                                    // Inverting zero yields zero, and so does a / 0.
                                    r_done              <= 1'b1;
                                    r_resp.result       <= '0;
                                    r_resp.zero_inverse <= 1'b1;
                                end else begin
                                    // The first quotient is zero, so begin straight
                                    // after the swap: (P, 0) over (x, 1).
                                    r_r     <= poly_eff;
                                    r_s     <= '0;
                                    r_v     <= {inv_src, 1'b0};
                                    r_w     <= W'(2);
                                    r_dr    <= r_n;
                                    r_dn    <= r_n - CW'(1);
                                    r_state <= ST_NORM;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                ST_NORM: begin
                    // Lower the divisor's assumed degree until its leading bit
                    // lines up with the top of the dividend.
                    if (r_v[r_dr]) begin
                        r_state <= ST_DIVI;
                    end else begin
                        r_v  <= r_v << 1;
                        r_w  <= r_w << 1;
                        r_dn <= r_dn - CW'(1);
                    end
                end

                ST_DIVI: begin
                    if (r_dr == r_dn) begin
                        // Division finished; v and w are now unshifted.
                        if (div_zero) begin
                            if (r_op == OP_DIV) begin
                                r_acc   <= '0;
                                r_mb    <= inv_res;
                                r_cnt   <= r_n - CW'(1);
                                r_state <= ST_MUL;
                            end else begin
                                r_done              <= 1'b1;
                                r_resp.result       <= DATA_WIDTH'(inv_res);
                                r_resp.zero_inverse <= 1'b0;
                                r_state             <= ST_IDLE;
                            end
                        end else begin
                            r_r     <= r_v;
                            r_s     <= r_w;
                            r_v     <= div_r << 1;
                            r_w     <= div_s << 1;
                            r_dr    <= r_dn;
                            r_dn    <= r_dn - CW'(1);
                            r_state <= ST_NORM;
                        end
                    end else begin
                        r_r  <= div_r;
                        r_s  <= div_s;
                        r_v  <= r_v >> 1;
                        r_w  <= r_w >> 1;
                        r_dr <= r_dr - CW'(1);
                    end
                end

                ST_MUL: begin
                    r_acc <= mul_acc;
                    r_mb  <= r_mb << 1;
                    if (r_cnt == '0) begin
                        r_done              <= 1'b1;
                        r_resp.result       <= DATA_WIDTH'(mul_acc);
                        r_resp.zero_inverse <= 1'b0;
                        r_state             <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt - CW'(1);
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign busy       = (r_state != ST_IDLE);
    assign o_done     = r_done;
    assign o_response = r_resp;

endmodule
